### rtl/core/md5_stream_hasher_defines.svh
// Assertion macros shared by the MD5 stream hasher RTL.
`ifndef MD5_STREAM_HASHER_DEFINES_SVH
`define MD5_STREAM_HASHER_DEFINES_SVH
`ifndef SYNTHESIS
// Checks a property on every rising edge of clk_i outside reset.
`define MD5_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checks that the consequent holds in the cycle after the antecedent.
`define MD5_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);
`else
`define MD5_ASSERT(lbl, prop, msg)
`define MD5_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/core/md5_pkg.sv
// Shared constants, tables, types and helper functions of the MD5 stream hasher.
`default_nettype none
package md5_pkg;

  localparam int unsigned WORD_W       = 32;
  localparam int unsigned BLOCK_WORDS  = 16;
  localparam int unsigned BLOCK_AW     = 4;
  localparam int unsigned ROUND_W      = 6;
  localparam int unsigned DIGEST_WORDS = 4;
  localparam int unsigned COUNT_W      = 3;
  localparam int unsigned INDEX_W      = 2;
  localparam int unsigned LENGTH_W     = 64;

  localparam logic [7:0]          PAD_BYTE   = 8'h80;
  localparam logic [BLOCK_AW-1:0] LEN_LO_POS = BLOCK_AW'(BLOCK_WORDS - 2);
  localparam logic [COUNT_W-1:0]  FULL_COUNT = COUNT_W'(4);

  localparam logic [WORD_W-1:0] START_VALUE [DIGEST_WORDS] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  localparam logic [WORD_W-1:0] ROUND_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROT_S [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // Working variables of the compression rounds.
  typedef struct packed {
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
    logic [WORD_W-1:0] d;
  } md5_work_t;

  // Message word that a given round reads from the block buffer.
  function automatic logic [BLOCK_AW-1:0] msg_index(input logic [ROUND_W-1:0] r);
    logic [BLOCK_AW-1:0] lo;
    logic [BLOCK_AW-1:0] idx;
    lo = r[BLOCK_AW-1:0];
    unique case (r[ROUND_W-1:ROUND_W-2])
      2'd0:    idx = lo;
      2'd1:    idx = BLOCK_AW'(lo * BLOCK_AW'(5) + BLOCK_AW'(1));
      2'd2:    idx = BLOCK_AW'(lo * BLOCK_AW'(3) + BLOCK_AW'(5));
      default: idx = BLOCK_AW'(lo * BLOCK_AW'(7));
    endcase
    return idx;
  endfunction

  // Left-rotate amount of a given round.
  function automatic logic [4:0] rot_amount(input logic [ROUND_W-1:0] r);
    return ROT_S[{r[ROUND_W-1:ROUND_W-2], r[1:0]}];
  endfunction

endpackage
`default_nettype wire

### rtl/core/md5_in_if.sv
// Input channel of the MD5 stream hasher: message words with byte count and last mark.
`default_nettype none
interface md5_in_if
  import md5_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [WORD_W-1:0]  message_word;
  logic [COUNT_W-1:0] byte_count;
  logic               final_item;

  modport source (output valid, output message_word, output byte_count,
                  output final_item, input ready);
  modport sink   (input valid, input message_word, input byte_count,
                  input final_item, output ready);
endinterface
`default_nettype wire

### rtl/core/md5_out_if.sv
// Output channel of the MD5 stream hasher: digest words with index and last mark.
`default_nettype none
interface md5_out_if
  import md5_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [WORD_W-1:0]  digest_word;
  logic [INDEX_W-1:0] word_index;
  logic               last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink   (input valid, input digest_word, input word_index,
                  input last_word, output ready);
endinterface
`default_nettype wire

### rtl/core/md5_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module md5_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### rtl/core/md5_round.sv
// One MD5 compression round, reused for all sixty-four rounds of a block.
`default_nettype none
module md5_round
  import md5_pkg::*;
(
  input  logic [ROUND_W-1:0] round_i,
  input  md5_work_t          work_i,
  input  logic [WORD_W-1:0]  ak_i,
  input  logic [WORD_W-1:0]  msg_i,
  output md5_work_t          work_o,
  output logic [WORD_W-1:0]  ak_o
);

  logic [WORD_W-1:0]     fn;
  logic [WORD_W-1:0]     sum;
  logic [2*WORD_W-1:0]   dbl;
  logic [ROUND_W-1:0]    round_nxt;

  always_comb begin
    unique case (round_i[ROUND_W-1:ROUND_W-2])
      2'd0:    fn = (work_i.b & work_i.c) | (~work_i.b & work_i.d);
      2'd1:    fn = (work_i.b & work_i.d) | (work_i.c & ~work_i.d);
      2'd2:    fn = work_i.b ^ work_i.c ^ work_i.d;
      default: fn = work_i.c ^ (work_i.b | ~work_i.d);
    endcase
  end

  // The a + K term was formed in the cycle before, so only three operands meet here.
  assign sum = ak_i + fn + msg_i;
  assign dbl = {sum, sum} << rot_amount(round_i);

  assign work_o.a = work_i.d;
  assign work_o.b = work_i.b + dbl[2*WORD_W-1:WORD_W];
  assign work_o.c = work_i.b;
  assign work_o.d = work_i.c;

  // The next round's a is the current d.
  assign round_nxt = ROUND_W'(round_i + ROUND_W'(1));
  assign ak_o      = work_i.d + ROUND_K[round_nxt];

endmodule
`default_nettype wire

### rtl/core/md5_stream_hasher.sv
// Top level of the MD5 stream hasher: input formatting, padding sequencer and digest output.
//
// Usage: message bytes arrive on in_i as little-endian 32-bit beats, first byte in
// bits 7..0, with byte_count (valid low bytes) and final_item marking the last beat.
// A count below four is honored only on the last beat; elsewhere the beat holds four bytes.
// in_i.ready is high only while the block waits for a beat. A beat that is neither
// last nor fills a 64-byte block leaves the block ready for the next beat. The beat
// that fills a block of 16 beats starts a compression: a step to prime the buffer
// read, 64 rounds through the shared round unit at one round per cycle, and a step
// to fold into the chaining values; no new beat is taken until it is done.
// After the last beat the sequencer writes the pad byte (unless a short last beat
// carried it), zero fill and the 64-bit bit length one word per cycle outside
// compressions, with one more compression when the length does not fit,
// then presents the digest on out_o as four beats, A to D, last_word on D.
// If the receiver stalls, the current digest beat holds until taken; no new message
// beat is taken until D is gone. Chaining values then return to their start values.
// Reset puts the chaining values at their start values and clears the byte length
// and block position; the block buffer RAM needs no clearing.
`default_nettype none
`include "md5_stream_hasher_defines.svh"
module md5_stream_hasher
  import md5_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  md5_in_if.sink    in_i,
  md5_out_if.source out_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FILL  = 6'b000010,
    S_PRIME = 6'b000100,
    S_ROUND = 6'b001000,
    S_FINAL = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

  state_e               state_q, state_d;
  logic [BLOCK_AW-1:0]  pos_q, pos_d;
  logic [ROUND_W-1:0]   round_q, round_d;
  logic [INDEX_W-1:0]   oidx_q, oidx_d;
  logic [LENGTH_W-1:0]  len_q, len_d;
  logic                 tail_q, tail_d;
  logic                 pad_done_q, pad_done_d;
  logic                 lenlo_q, lenlo_d;
  logic                 fin_q, fin_d;
  logic [WORD_W-1:0]    chain_q [DIGEST_WORDS];
  logic [WORD_W-1:0]    chain_d [DIGEST_WORDS];
  md5_work_t            work_q, work_d, work_next;
  logic [WORD_W-1:0]    ak_q, ak_d, ak_next;

  logic                 in_acc;
  logic                 out_acc;
  logic [COUNT_W-1:0]   cnt;
  logic                 short_last;
  logic [WORD_W-1:0]    fmt_word;
  logic [LENGTH_W-1:0]  len_bits;
  logic                 push_en;
  logic [WORD_W-1:0]    push_word;
  logic [BLOCK_AW-1:0]  raddr;
  logic [WORD_W-1:0]    rdata;

  assign in_acc  = in_i.valid & in_i.ready;
  assign out_acc = out_o.valid & out_o.ready;

  // Short counts only count on the last beat; anything above four saturates.
  assign short_last = in_i.final_item && (in_i.byte_count < FULL_COUNT);
  assign cnt        = short_last ? in_i.byte_count : FULL_COUNT;

  // Keep the valid bytes, and on a short last beat drop the pad byte right behind them.
  always_comb begin
    for (int k = 0; k < WORD_W / 8; k++) begin
      if (COUNT_W'(k) < cnt) begin
        fmt_word[8*k +: 8] = in_i.message_word[8*k +: 8];
      end else if (COUNT_W'(k) == cnt) begin
        fmt_word[8*k +: 8] = PAD_BYTE;
      end else begin
        fmt_word[8*k +: 8] = 8'h00;
      end
    end
  end

  assign len_bits = {len_q[LENGTH_W-4:0], 3'b000};

  always_comb begin
    state_d    = state_q;
    pos_d      = pos_q;
    round_d    = round_q;
    oidx_d     = oidx_q;
    len_d      = len_q;
    tail_d     = tail_q;
    pad_done_d = pad_done_q;
    lenlo_d    = lenlo_q;
    fin_d      = fin_q;
    chain_d    = chain_q;
    work_d     = work_q;
    ak_d       = ak_q;
    push_en    = 1'b0;
    push_word  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          push_en   = 1'b1;
          push_word = fmt_word;
          pos_d     = BLOCK_AW'(pos_q + BLOCK_AW'(1));
          len_d     = len_q + LENGTH_W'(cnt);
          if (in_i.final_item) begin
            tail_d     = 1'b1;
            pad_done_d = short_last;
          end
          if (pos_q == '1) begin
            state_d = S_PRIME;
          end else if (in_i.final_item) begin
            state_d = S_FILL;
          end
        end
      end
      S_FILL: begin
        push_en = 1'b1;
        pos_d   = BLOCK_AW'(pos_q + BLOCK_AW'(1));
        priority if (!pad_done_q) begin
          push_word  = WORD_W'(PAD_BYTE);
          pad_done_d = 1'b1;
        end else if (lenlo_q) begin
          push_word = len_bits[LENGTH_W-1:WORD_W];
          fin_d     = 1'b1;
        end else if (pos_q == LEN_LO_POS) begin
          push_word = len_bits[WORD_W-1:0];
          lenlo_d   = 1'b1;
        end else begin
          push_word = '0;
        end
        if (pos_q == '1) begin
          state_d = S_PRIME;
        end
      end
      S_PRIME: begin
        work_d  = '{a: chain_q[0], b: chain_q[1], c: chain_q[2], d: chain_q[3]};
        ak_d    = chain_q[0] + ROUND_K[0];
        round_d = '0;
        state_d = S_ROUND;
      end
      S_ROUND: begin
        work_d  = work_next;
        ak_d    = ak_next;
        round_d = ROUND_W'(round_q + ROUND_W'(1));
        if (round_q == '1) begin
          state_d = S_FINAL;
        end
      end
      S_FINAL: begin
        chain_d[0] = chain_q[0] + work_q.a;
        chain_d[1] = chain_q[1] + work_q.b;
        chain_d[2] = chain_q[2] + work_q.c;
        chain_d[3] = chain_q[3] + work_q.d;
        if (fin_q) begin
          state_d = S_OUT;
        end else if (tail_q) begin
          state_d = S_FILL;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_OUT: begin
        if (out_acc) begin
          oidx_d = INDEX_W'(oidx_q + INDEX_W'(1));
          if (oidx_q == '1) begin
            chain_d    = START_VALUE;
            len_d      = '0;
            pos_d      = '0;
            tail_d     = 1'b0;
            pad_done_d = 1'b0;
            lenlo_d    = 1'b0;
            fin_d      = 1'b0;
            state_d    = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // The buffer read is registered, so each round's word is addressed in the cycle before.
  assign raddr = (state_q == S_PRIME) ? msg_index('0)
                                      : msg_index(ROUND_W'(round_q + ROUND_W'(1)));

  md5_ram #(
    .WIDTH (WORD_W),
    .DEPTH (BLOCK_WORDS)
  ) u_block_buf (
    .clk_i   (clk_i),
    .we_i    (push_en),
    .waddr_i (pos_q),
    .wdata_i (push_word),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  md5_round u_round (
    .round_i (round_q),
    .work_i  (work_q),
    .ak_i    (ak_q),
    .msg_i   (rdata),
    .work_o  (work_next),
    .ak_o    (ak_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      pos_q      <= '0;
      round_q    <= '0;
      oidx_q     <= '0;
      len_q      <= '0;
      tail_q     <= 1'b0;
      pad_done_q <= 1'b0;
      lenlo_q    <= 1'b0;
      fin_q      <= 1'b0;
      chain_q    <= START_VALUE;
    end else begin
      state_q    <= state_d;
      pos_q      <= pos_d;
      round_q    <= round_d;
      oidx_q     <= oidx_d;
      len_q      <= len_d;
      tail_q     <= tail_d;
      pad_done_q <= pad_done_d;
      lenlo_q    <= lenlo_d;
      fin_q      <= fin_d;
      chain_q    <= chain_d;
    end
  end

  // The working variables are only read during a compression, after priming.
  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    ak_q   <= ak_d;
  end

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = (state_q == S_OUT);
  assign out_o.digest_word = chain_q[oidx_q];
  assign out_o.word_index  = oidx_q;
  assign out_o.last_word   = (oidx_q == '1);

  // A compression only starts on a completely written block.
  `MD5_ASSERT(a_prime_full_block, state_q == S_PRIME |-> pos_q == '0, "compression on partial block")
  // The digest only goes out after the length words closed the final block.
  `MD5_ASSERT(a_out_after_len,
              out_o.valid |-> fin_q && lenlo_q && pad_done_q && pos_q == '0,
              "digest before length")
  // Checks that a taken last beat drops ready, so no beat follows it during padding.
  `MD5_ASSERT_NEXT(a_last_blocks_input, in_acc && in_i.final_item, !in_i.ready, "beat taken during padding")
  // Once word D is taken the block is back at the start of a fresh message.
  `MD5_ASSERT_NEXT(a_restart, out_acc && out_o.last_word,
                   state_q == S_IDLE && len_q == '0 &&
                   chain_q[0] == START_VALUE[0] && chain_q[3] == START_VALUE[3],
                   "no restart after digest")

endmodule
`default_nettype wire

### sim/tb_top.sv
// Self-checking testbench of the MD5 stream hasher: directed and random messages, digests checked.
module tb_top;
  import md5_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Standard MD5 chaining start values, A to D.
  localparam logic [31:0] HASH_IV [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };
  localparam logic [31:0] PAD_MARK   = 32'h0000_0080;
  localparam int unsigned LEN_SLOT   = 14;
  localparam int unsigned BEAT_BYTES = 4;

  // Position of a digest beat within the digest.
  typedef enum logic [1:0] {
    WORD_A = 2'd0,
    WORD_B = 2'd1,
    WORD_C = 2'd2,
    WORD_D = 2'd3
  } digest_word_e;

  // One digest beat as it should appear on the output channel.
  typedef struct packed {
    logic [WORD_W-1:0]  word;
    logic [INDEX_W-1:0] index;
    logic               last;
  } digest_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  md5_in_if  in_ch ();
  md5_out_if out_ch ();

  md5_stream_hasher u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always #5 clk_i = ~clk_i;

  // Digest model state: chaining values, the message block being filled,
  // the running byte count and the next free word slot of the block.
  logic [31:0]        hash_state [4];
  logic [31:0]        msg_block  [16];
  logic [63:0]        msg_bytes;
  logic [3:0]         blk_slot;
  logic [31:0]        round_const [64];
  int unsigned        rot_tab [4][4] = '{
    '{7, 12, 17, 22}, '{5, 9, 14, 20}, '{4, 11, 16, 23}, '{6, 10, 15, 21}
  };

  digest_beat_t       expected_digest_q [$];
  int unsigned        mismatch_count;
  int unsigned        beats_sent;

  // Switches for the random idling on either side of the block.
  bit                 send_gaps_on;
  bit                 recv_stalls_on;

  // The round constants are the integer part of |sin(i+1)| * 2^32, as the
  // standard defines them, so they are derived here rather than tabulated.
  function automatic void build_round_consts();
    real s;
    for (int i = 0; i < 64; i++) begin
      s = $sin(real'(i + 1));
      if (s < 0.0) begin
        s = -s;
      end
      round_const[i] = 32'(longint'($floor(s * 4294967296.0)));
    end
  endfunction

  function automatic void restart_hash();
    for (int k = 0; k < 4; k++) begin
      hash_state[k] = HASH_IV[k];
    end
    msg_bytes = 64'd0;
    blk_slot  = 4'd0;
  endfunction

  // The 64 rounds over a full block, folded into the chaining values.
  function automatic void md5_compress();
    logic [31:0] a, b, c, d, f, t;
    int unsigned g, s;
    a = hash_state[0];
    b = hash_state[1];
    c = hash_state[2];
    d = hash_state[3];
    for (int unsigned r = 0; r < 64; r++) begin
      case (r / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = r;
        end
        1: begin
          f = (d & b) | (~d & c);
          g = (5 * r + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * r + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * r) % 16;
        end
      endcase
      s = rot_tab[r / 16][r % 4];
      t = a + f + round_const[r] + msg_block[g];
      a = d;
      d = c;
      c = b;
      b = b + ((t << s) | (t >> (32 - s)));
    end
    hash_state[0] += a;
    hash_state[1] += b;
    hash_state[2] += c;
    hash_state[3] += d;
  endfunction

  function automatic void store_block_word(input logic [31:0] w);
    msg_block[blk_slot] = w;
    blk_slot = blk_slot + 4'd1;
    if (blk_slot == 4'd0) begin
      md5_compress();
    end
  endfunction

  // Takes one accepted input beat into the model. On the last beat it pads,
  // appends the bit length and queues the four digest beats it expects.
  function automatic void absorb_beat(input logic [31:0] w, input logic [2:0] cnt,
                                      input logic fin);
    int unsigned  n;
    logic [63:0]  bit_len;
    digest_beat_t beat;
    n = (!fin || cnt > 3'd4) ? BEAT_BYTES : int'(cnt);
    if (n < BEAT_BYTES) begin
      w &= (32'd1 << (8 * n)) - 32'd1;
    end
    msg_bytes += 64'(n);
    if (!fin) begin
      store_block_word(w);
      return;
    end
    if (n < BEAT_BYTES) begin
      store_block_word(w | (PAD_MARK << (8 * n)));
    end else begin
      store_block_word(w);
      store_block_word(PAD_MARK);
    end
    // Zero fill up to the length slots, which may take a whole extra block.
    if (blk_slot > 4'(LEN_SLOT)) begin
      store_block_word(32'd0);
    end
    while (blk_slot != 4'(LEN_SLOT)) begin
      store_block_word(32'd0);
    end
    bit_len = msg_bytes << 3;
    store_block_word(bit_len[31:0]);
    store_block_word(bit_len[63:32]);
    for (int k = 0; k < 4; k++) begin
      beat.word  = hash_state[k];
      beat.index = digest_word_e'(k);
      beat.last  = (k == WORD_D);
      expected_digest_q.push_back(beat);
    end
    restart_hash();
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR %0t ns: %s: got %h, expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // With the switch on: mostly no gap, often a short one, now and then a long one; with it off, never a gap.
  function automatic int unsigned pick_idle(input bit enabled);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 60) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Sends one input beat. Valid stays high when no gap follows, so a run of
  // beats without gaps goes out back to back.
  task automatic send_beat(input logic [31:0] w, input logic [2:0] cnt, input logic fin);
    int unsigned gap;
    gap = pick_idle(send_gaps_on);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.message_word <= w;
    in_ch.byte_count   <= cnt;
    in_ch.final_item   <= fin;
    do @(posedge clk_i); while (!in_ch.ready);
    absorb_beat(w, cnt, fin);
    beats_sent++;
  endtask

  // Holds the sender off until every queued digest beat has come out.
  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    while (expected_digest_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // A message of n beats with random content. With noise on, some beats
  // that are not last carry odd byte counts, which the block must read as four.
  task automatic send_message(input int unsigned n, input logic [2:0] last_cnt,
                              input bit noisy);
    logic [2:0] cnt;
    for (int unsigned i = 1; i < n; i++) begin
      cnt = 3'(BEAT_BYTES);
      if (noisy && $urandom_range(0, 4) == 0) begin
        cnt = 3'($urandom_range(0, 7));
      end
      send_beat(pick_word(), cnt, 1'b0);
    end
    send_beat(pick_word(), last_cnt, 1'b1);
  endtask

  // Message lengths are mostly short and else cluster around the block boundaries,
  // where the pad and the length field either fit or spill into an extra block.
  function automatic int unsigned pick_length();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return $urandom_range(1, 8);
      6, 7:             return $urandom_range(13, 18);
      8:                return $urandom_range(29, 34);
      default:          return $urandom_range(1, 40);
    endcase
  endfunction

  // Field extremes and the special cases of the padding rules.
  task automatic test_directed_cases();
    send_gaps_on   = 1'b1;
    recv_stalls_on = 1'b1;
    // Empty message: a last beat with no valid bytes, junk above them.
    send_beat(32'hFFFF_FFFF, 3'd0, 1'b1);
    // Three bytes "abc" with a junk top byte that must be dropped.
    send_beat(32'hFF63_6261, 3'd3, 1'b1);
    // A full last beat, so the pad byte opens a word of its own.
    send_beat(32'hFFFF_FFFF, 3'd4, 1'b1);
    // Counts above four saturate to a full beat.
    send_beat(32'h0000_0000, 3'd5, 1'b1);
    send_beat(32'hFFFF_FFFF, 3'd6, 1'b1);
    send_beat(32'h89AB_CDEF, 3'd7, 1'b1);
    // Short counts on beats that are not last still mean four bytes.
    send_beat(32'hFFFF_FFFF, 3'd0, 1'b0);
    send_beat(32'h0000_0000, 3'd1, 1'b1);
    send_beat(32'h1234_5678, 3'd3, 1'b0);
    send_beat(32'hFFFF_FFFF, 3'd2, 1'b1);
    // 55 bytes: the pad and the length just fit the first block.
    for (int i = 0; i < 13; i++) begin
      send_beat(32'h6161_6161, 3'd4, 1'b0);
    end
    send_beat(32'hFF61_6161, 3'd3, 1'b1);
  endtask

  // Bulk of the run: random messages with idling on both sides, and now and
  // then a pause until the block has handed out everything it owes.
  task automatic test_random_messages(input int unsigned beat_goal);
    int unsigned msg_no;
    send_gaps_on   = 1'b1;
    recv_stalls_on = 1'b1;
    msg_no = 0;
    while (beats_sent < beat_goal) begin
      send_message(pick_length(), 3'($urandom_range(0, 7)), $urandom_range(0, 3) == 0);
      msg_no++;
      if (msg_no % 12 == 0) begin
        hold_until_drained();
      end
    end
  endtask

  // No idling on either side: the block runs at its own pace.
  task automatic test_back_to_back();
    send_gaps_on   = 1'b0;
    recv_stalls_on = 1'b0;
    send_message(16, 3'd4, 1'b0);
    send_message(1, 3'd0, 1'b0);
    send_message(14, 3'd0, 1'b0);
    send_message(2, 3'($urandom_range(0, 7)), 1'b1);
  endtask

  // Output side: checks every accepted digest beat against the oldest
  // expectation, then decides whether the next cycle is a stall.
  initial begin : digest_checker
    digest_beat_t want;
    int unsigned  stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid && out_ch.ready) begin
        if (expected_digest_q.size() == 0) begin
          report_mismatch("digest beat with none expected", out_ch.digest_word, 32'd0);
        end else begin
          want = expected_digest_q.pop_front();
          if (out_ch.digest_word !== want.word) begin
            report_mismatch("digest_word", out_ch.digest_word, want.word);
          end
          if (out_ch.word_index !== want.index) begin
            report_mismatch("word_index", 32'(out_ch.word_index), 32'(want.index));
          end
          if (out_ch.last_word !== want.last) begin
            report_mismatch("last_word", 32'(out_ch.last_word), 32'(want.last));
          end
        end
      end
      if (stall_left != 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left = pick_idle(recv_stalls_on);
      end
    end
  end

  // Main sequence. Reset is applied once; afterwards the tests run in turn.
  initial begin
    mismatch_count     = 0;
    beats_sent         = 0;
    send_gaps_on       = 1'b0;
    recv_stalls_on     = 1'b0;
    rst_ni             = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.message_word = '0;
    in_ch.byte_count   = '0;
    in_ch.final_item   = 1'b0;
    build_round_consts();
    restart_hash();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_random_messages(440);
    test_back_to_back();

    // Wait out the last digest, then idle on to catch stray beats.
    in_ch.valid <= 1'b0;
    while (expected_digest_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
